// File: hdl/lru_image_cache_tag_store_macros.svh
// assertion helpers used by the tag store datapath
`ifndef LRU_IMAGE_CACHE_TAG_STORE_MACROS_SVH
`define LRU_IMAGE_CACHE_TAG_STORE_MACROS_SVH

// same-cycle implication, checked on clk outside reset
`define LICTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk outside reset
`define LICTS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/licts_pkg.sv
package licts_pkg;

  // field widths
  localparam int PHOTO_COUNT_W = 9;
  localparam int INDEX_W       = 8;
  localparam int TAG_W         = 32;
  localparam int DIM_W         = 10;
  localparam int STATUS_W      = 3;
  localparam int STAMP_W       = 32;

  // parameter defaults
  localparam int CACHE_SLOTS_DEF = 4;
  localparam int MAX_PHOTOS_DEF  = 256;

  // result status codes
  typedef logic [STATUS_W-1:0] status_t;
  localparam status_t ST_HIT         = 3'd0;
  localparam status_t ST_MISS        = 3'd1;
  localparam status_t ST_BAD_INDEX   = 3'd2;
  localparam status_t ST_STORED      = 3'd3;
  localparam status_t ST_UNCACHED    = 3'd4;
  localparam status_t ST_DECODE_FAIL = 3'd5;
  localparam status_t ST_NO_PENDING  = 3'd6;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic scan_step;
    logic mul;
    logic commit;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } ctl_stat_t;

endpackage

// File: hdl/licts_ctrl.sv
module licts_ctrl
  import licts_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_kind,
  output logic      in_stall,
  input  ctl_stat_t stat,
  output ctl_cmd_t  cmd
);

  typedef enum logic [1:0] {S_IDLE, S_LOOK, S_MUL, S_RESP} state_t;

  state_t state_r;
  logic   in_stall_r;

  // sequencer: capture, walk or multiply, then respond
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_stall_r <= 1'b1;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid && !in_stall_r) begin
            in_stall_r <= 1'b1;
            state_r    <= in_kind ? S_MUL : S_LOOK;
          end else begin
            in_stall_r <= 1'b0;
          end
        end
        S_LOOK: begin
          if (stat.scan_done) state_r <= S_RESP;
        end
        S_MUL: begin
          state_r <= S_RESP;
        end
        S_RESP: begin
          if (stat.out_free) begin
            state_r    <= S_IDLE;
            in_stall_r <= 1'b0;
          end
        end
        default: begin
          state_r    <= S_IDLE;
          in_stall_r <= 1'b1;
        end
      endcase
    end
  end

  // commands decoded from state
  always_comb begin
    cmd.capture   = (state_r == S_IDLE) && in_valid && !in_stall_r;
    cmd.scan_step = (state_r == S_LOOK);
    cmd.mul       = (state_r == S_MUL);
    cmd.commit    = (state_r == S_RESP) && stat.out_free;
  end

  assign in_stall = in_stall_r;

endmodule

// File: hdl/licts_dp.sv
`include "lru_image_cache_tag_store_macros.svh"

module licts_dp
  import licts_pkg::*;
#(
  parameter int CACHE_SLOTS = CACHE_SLOTS_DEF,
  parameter int MAX_PHOTOS  = MAX_PHOTOS_DEF,
  localparam int SLOT_W     = $clog2(CACHE_SLOTS)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_valid,
  input  logic [PHOTO_COUNT_W-1:0] cfg_photo_count,
  input  logic                     in_kind,
  input  logic [INDEX_W-1:0]       in_photo_index,
  input  logic [TAG_W-1:0]         in_photo_tag,
  input  logic [DIM_W-1:0]         in_width,
  input  logic [DIM_W-1:0]         in_height,
  input  logic                     in_decode_ok,
  input  logic                     in_alloc_ok,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [STATUS_W-1:0]      out_status,
  output logic [SLOT_W-1:0]        out_slot,
  input  ctl_cmd_t                 cmd,
  output ctl_stat_t                stat
);

  localparam int MAXP_W = $clog2(MAX_PHOTOS + 1);
  localparam int LIM_W  = (MAXP_W > PHOTO_COUNT_W) ? MAXP_W : PHOTO_COUNT_W;
  localparam logic [LIM_W-1:0] MaxLim = LIM_W'(MAX_PHOTOS);
  localparam logic [SLOT_W-1:0] LastSlot = SLOT_W'(CACHE_SLOTS - 1);

  // configuration
  logic [PHOTO_COUNT_W-1:0] photo_count_r;

  // captured word
  logic               kind_r;
  logic [INDEX_W-1:0] idx_r;
  logic [TAG_W-1:0]   tag_r;
  logic [DIM_W-1:0]   wid_r;
  logic [DIM_W-1:0]   hgt_r;
  logic               decode_ok_r;
  logic               alloc_ok_r;

  // entry store
  logic               ent_valid_r [CACHE_SLOTS];
  logic [TAG_W-1:0]   ent_tag_r   [CACHE_SLOTS];
  logic [DIM_W-1:0]   ent_wid_r   [CACHE_SLOTS];
  logic [DIM_W-1:0]   ent_hgt_r   [CACHE_SLOTS];
  logic [STAMP_W-1:0] ent_stamp_r [CACHE_SLOTS];
  logic [STAMP_W-1:0] use_clock_r;

  // pending miss
  logic              pend_r;
  logic [SLOT_W-1:0] pend_slot_r;
  logic [TAG_W-1:0]  pend_tag_r;
  logic [DIM_W-1:0]  pend_wid_r;
  logic [DIM_W-1:0]  pend_hgt_r;

  // walk state
  logic [SLOT_W-1:0]  scan_idx_r;
  logic               hit_r;
  logic [SLOT_W-1:0]  hit_slot_r;
  logic [SLOT_W-1:0]  victim_r;
  logic [STAMP_W-1:0] best_r;

  // fill size products
  logic [2*DIM_W-1:0] prod_ent_r;
  logic [2*DIM_W-1:0] prod_pend_r;

  // result register
  logic                out_valid_r;
  status_t             out_status_r;
  logic [SLOT_W-1:0]   out_slot_r;

  // commit decode
  logic               hit_now;
  logic               scan_last;
  logic [LIM_W-1:0]   cnt_ext;
  logic [LIM_W-1:0]   lim;
  logic               bad_idx;
  logic               need_buf;
  status_t            res_status;
  logic [SLOT_W-1:0]  res_slot;
  logic               stamp_we;
  logic [SLOT_W-1:0]  wr_slot;
  logic               key_we;
  logic               inval_we;
  logic               pend_set;
  logic               pend_clr;
  logic [STAMP_W-1:0] clock_nxt;
  logic               res_ticks;

  // photo count register
  always_ff @(posedge clk) begin
    if (!rst_n) photo_count_r <= '0;
    else if (cfg_valid) photo_count_r <= cfg_photo_count;
  end

  // capture the accepted word
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r      <= in_kind;
      idx_r       <= in_photo_index;
      tag_r       <= in_photo_tag;
      wid_r       <= in_width;
      hgt_r       <= in_height;
      decode_ok_r <= in_decode_ok;
      alloc_ok_r  <= in_alloc_ok;
    end
  end

  // one slot per cycle: match check and least-stamp tracking
  assign hit_now   = ent_valid_r[scan_idx_r] && (ent_tag_r[scan_idx_r] == tag_r) &&
                     (ent_wid_r[scan_idx_r] == wid_r) && (ent_hgt_r[scan_idx_r] == hgt_r);
  assign scan_last = (scan_idx_r == LastSlot);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
      hit_r      <= 1'b0;
    end else if (cmd.capture) begin
      scan_idx_r <= '0;
      hit_r      <= 1'b0;
    end else if (cmd.scan_step) begin
      if (hit_now) begin
        hit_r <= 1'b1;
      end else if (!scan_last) begin
        scan_idx_r <= scan_idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step) begin
      if (hit_now) begin
        hit_slot_r <= scan_idx_r;
      end else if ((scan_idx_r == '0) || (ent_stamp_r[scan_idx_r] < best_r)) begin
        best_r   <= ent_stamp_r[scan_idx_r];
        victim_r <= scan_idx_r;
      end
    end
  end

  // size products for the fill decision
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_ent_r  <= (2*DIM_W)'(ent_wid_r[pend_slot_r]) * (2*DIM_W)'(ent_hgt_r[pend_slot_r]);
      prod_pend_r <= (2*DIM_W)'(pend_wid_r) * (2*DIM_W)'(pend_hgt_r);
    end
  end

  // bad index against the limited photo count
  assign cnt_ext = LIM_W'(photo_count_r);
  assign lim     = (cnt_ext > MaxLim) ? MaxLim : cnt_ext;
  assign bad_idx = (LIM_W'(idx_r) >= lim);
  assign need_buf  = !ent_valid_r[pend_slot_r] || (prod_ent_r != prod_pend_r);
  assign clock_nxt = use_clock_r + 1'b1;

  // result and update decode
  always_comb begin
    res_status = ST_NO_PENDING;
    res_slot   = '0;
    stamp_we   = 1'b0;
    wr_slot    = pend_slot_r;
    key_we     = 1'b0;
    inval_we   = 1'b0;
    pend_set   = 1'b0;
    pend_clr   = 1'b0;
    if (!kind_r) begin
      pend_clr = 1'b1;
      if (bad_idx) begin
        res_status = ST_BAD_INDEX;
      end else if (hit_r) begin
        res_status = ST_HIT;
        res_slot   = hit_slot_r;
        wr_slot    = hit_slot_r;
        stamp_we   = 1'b1;
      end else begin
        res_status = ST_MISS;
        res_slot   = victim_r;
        pend_set   = 1'b1;
      end
    end else if (pend_r) begin
      pend_clr = 1'b1;
      res_slot = pend_slot_r;
      if (!decode_ok_r) begin
        res_status = ST_DECODE_FAIL;
      end else if (need_buf && !alloc_ok_r) begin
        res_status = ST_UNCACHED;
        inval_we   = 1'b1;
      end else begin
        res_status = ST_STORED;
        key_we     = 1'b1;
        stamp_we   = 1'b1;
      end
    end
  end

  // control part of the store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CACHE_SLOTS; i++) begin
        ent_valid_r[i] <= 1'b0;
        ent_stamp_r[i] <= '0;
      end
      use_clock_r <= '0;
      pend_r      <= 1'b0;
      pend_slot_r <= '0;
    end else if (cmd.commit) begin
      if (stamp_we) begin
        ent_stamp_r[wr_slot] <= clock_nxt;
        use_clock_r          <= clock_nxt;
      end
      if (key_we) ent_valid_r[wr_slot] <= 1'b1;
      if (inval_we) ent_valid_r[wr_slot] <= 1'b0;
      if (pend_set) begin
        pend_r      <= 1'b1;
        pend_slot_r <= victim_r;
      end else if (pend_clr) begin
        pend_r <= 1'b0;
      end
    end
  end

  // key part of the store and pending key
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (key_we) begin
        ent_tag_r[wr_slot] <= pend_tag_r;
        ent_wid_r[wr_slot] <= pend_wid_r;
        ent_hgt_r[wr_slot] <= pend_hgt_r;
      end
      if (pend_set) begin
        pend_tag_r <= tag_r;
        pend_wid_r <= wid_r;
        pend_hgt_r <= hgt_r;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r <= res_status;
      out_slot_r   <= res_slot;
    end
  end

  assign stat.scan_done = hit_now || scan_last;
  assign stat.out_free  = !out_valid_r || !out_stall;

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_slot   = out_slot_r;

  // results that advance the use clock
  assign res_ticks = (out_status_r == ST_HIT) || (out_status_r == ST_STORED);

  `LICTS_ASSERT_IMP(a_commit_free, cmd.commit, stat.out_free, "commit onto full output")
  `LICTS_ASSERT_NXT(a_commit_shows, cmd.commit, out_valid_r, "commit without result")
  `LICTS_ASSERT_IMP(a_pend_from_miss, $rose(pend_r), $past(cmd.commit && !kind_r), "stray pending")
  `LICTS_ASSERT_NXT(a_clock_tick, cmd.commit, res_ticks == $changed(use_clock_r), "clock step")

endmodule

// File: hdl/lru_image_cache_tag_store.sv
// lookup: accept, then the tag walk, then the commit of the result; the next request
//   is accepted only after that commit. The walk visits one slot per cycle and stops early on a hit
// fill: accept, then register the two size products, then commit
// result word registered at the commit, which waits while the output holds an unaccepted result
// synchronous active-low reset clears entries, stamps, use clock, pending miss and count
module lru_image_cache_tag_store
  import licts_pkg::*;
#(
  parameter int CACHE_SLOTS = CACHE_SLOTS_DEF,
  parameter int MAX_PHOTOS  = MAX_PHOTOS_DEF,
  localparam int SLOT_W     = $clog2(CACHE_SLOTS)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [PHOTO_COUNT_W-1:0] cfg_photo_count,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_kind,
  input  logic [INDEX_W-1:0]       in_photo_index,
  input  logic [TAG_W-1:0]         in_photo_tag,
  input  logic [DIM_W-1:0]         in_width,
  input  logic [DIM_W-1:0]         in_height,
  input  logic                     in_decode_ok,
  input  logic                     in_alloc_ok,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [STATUS_W-1:0]      out_status,
  output logic [SLOT_W-1:0]        out_slot
);

  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  // configuration writes always taken
  assign cfg_ready = 1'b1;

  // sequencer
  licts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // tag store, walk and result register
  licts_dp #(
    .CACHE_SLOTS (CACHE_SLOTS),
    .MAX_PHOTOS  (MAX_PHOTOS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_photo_count (cfg_photo_count),
    .in_kind         (in_kind),
    .in_photo_index  (in_photo_index),
    .in_photo_tag    (in_photo_tag),
    .in_width        (in_width),
    .in_height       (in_height),
    .in_decode_ok    (in_decode_ok),
    .in_alloc_ok     (in_alloc_ok),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_slot        (out_slot),
    .cmd             (cmd),
    .stat            (stat)
  );

endmodule
